### rtl/core/clh_pkg.sv
package clh_pkg;

  localparam int unsigned CRC_W     = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned RUN_W     = 2;

  localparam logic [CRC_W-1:0]  CRC_POLY   = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]  SEED_RESET = 32'd1234;
  localparam logic [BYTE_W-1:0] HASH_CHAR  = 8'h23;
  localparam logic [BYTE_W-1:0] END_CHAR   = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b1;

  localparam logic [RUN_W-1:0] RUN_NONE  = 2'd0;
  localparam logic [RUN_W-1:0] RUN_ONE   = 2'd1;
  localparam logic [RUN_W-1:0] RUN_TWO   = 2'd2;
  localparam logic [RUN_W-1:0] RUN_THREE = 2'd3;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;

  function automatic crc_t crc_byte(input crc_t crc, input byte_t data);
    crc_t c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage

### rtl/core/clh_in_if.sv
interface clh_in_if;
  logic                 valid;
  logic                 ready;
  clh_pkg::byte_t       data_byte;
  logic                 last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/clh_out_if.sv
interface clh_out_if;
  logic           valid;
  logic           ready;
  clh_pkg::crc_t  hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

### rtl/core/crc32_label_hash_top.sv
// A request is registered in the input stage and its hash, if it ends a message, is then
// registered in the result register. Throughput: one byte per cycle unless the result
// register is blocked, set by the single-byte CRC update in the state loop.
// Reset is synchronous and active low: seed returns to 1234, length mode is selected,
// the running CRC is set to the inverted seed and both pipeline valids are cleared.
module crc32_label_hash_top (
  input  logic                             clk,
  input  logic                             rst_n,
  clh_in_if.sink                           in_chan,
  clh_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [clh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clh_pkg::CRC_W-1:0]        cfg_wdata
);

  clh_pkg::crc_t  seed_r;
  logic           mode_r;
  clh_pkg::crc_t  running_r, running_nxt;
  clh_pkg::crc_t  shadow_r, shadow_nxt;
  logic [clh_pkg::RUN_W-1:0] run_cnt_r, run_cnt_nxt;

  logic           s1_valid_r;
  clh_pkg::byte_t s1_byte_r;
  logic           s1_last_r;

  logic           out_valid_r, out_valid_nxt;
  clh_pkg::crc_t  out_hash_r, out_hash_nxt;

  logic           s1_adv;
  logic           s1_fire;
  logic           emit;
  clh_pkg::crc_t  crc_run;
  clh_pkg::crc_t  crc_shadow;
  clh_pkg::crc_t  crc_seed;

  assign s1_adv  = !out_valid_r || out_chan.ready;
  assign s1_fire = s1_valid_r && s1_adv;
  assign in_chan.ready = !s1_valid_r || s1_adv;

  assign crc_run    = clh_pkg::crc_byte(running_r, s1_byte_r);
  assign crc_shadow = clh_pkg::crc_byte(shadow_r, clh_pkg::HASH_CHAR);
  assign crc_seed   = clh_pkg::crc_byte(~seed_r, clh_pkg::HASH_CHAR);

  always_comb begin
    running_nxt   = running_r;
    shadow_nxt    = shadow_r;
    run_cnt_nxt   = run_cnt_r;
    emit          = 1'b0;
    out_hash_nxt  = out_hash_r;
    if (s1_fire) begin
      if (mode_r) begin
        if (s1_byte_r == clh_pkg::END_CHAR) begin
          emit         = 1'b1;
          out_hash_nxt = ~running_r;
          running_nxt  = ~seed_r;
          run_cnt_nxt  = clh_pkg::RUN_NONE;
        end else if (s1_byte_r == clh_pkg::HASH_CHAR) begin
          case (run_cnt_r)
            clh_pkg::RUN_NONE: begin
              run_cnt_nxt = clh_pkg::RUN_ONE;
              running_nxt = crc_run;
              shadow_nxt  = crc_seed;
            end
            clh_pkg::RUN_ONE: begin
              run_cnt_nxt = clh_pkg::RUN_TWO;
              running_nxt = crc_run;
              shadow_nxt  = crc_shadow;
            end
            clh_pkg::RUN_TWO: begin
              run_cnt_nxt = clh_pkg::RUN_THREE;
              running_nxt = crc_shadow;
              shadow_nxt  = crc_shadow;
            end
            default: begin
              running_nxt = shadow_r;
            end
          endcase
        end else begin
          run_cnt_nxt = clh_pkg::RUN_NONE;
          running_nxt = crc_run;
        end
      end else begin
        if (s1_last_r) begin
          emit         = 1'b1;
          out_hash_nxt = ~crc_run;
          running_nxt  = ~seed_r;
        end else begin
          running_nxt  = crc_run;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= clh_pkg::SEED_RESET;
      mode_r      <= 1'b0;
      running_r   <= ~clh_pkg::SEED_RESET;
      run_cnt_r   <= clh_pkg::RUN_NONE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          clh_pkg::CFG_SEED: begin
            seed_r    <= cfg_wdata;
            running_r <= ~cfg_wdata;
          end
          clh_pkg::CFG_MODE: begin
            mode_r    <= cfg_wdata[0];
            running_r <= ~seed_r;
          end
          default: begin
            running_r <= running_r;
          end
        endcase
        run_cnt_r <= clh_pkg::RUN_NONE;
      end else begin
        running_r <= running_nxt;
        run_cnt_r <= run_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    shadow_r   <= shadow_nxt;
    out_hash_r <= out_hash_nxt;
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hash_value = out_hash_r;

  // The run counter only moves in terminated mode.
  a_run_idle_in_length_mode: assert property (@(posedge clk) disable iff (!rst_n)
    !mode_r |-> run_cnt_r == clh_pkg::RUN_NONE)
    else $error("run count nonzero in length mode");

  // A finished message leaves the running value at the inverted seed.
  a_restart_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !cfg_we |=> running_r == ~seed_r && run_cnt_r == clh_pkg::RUN_NONE)
    else $error("running CRC not restarted after a hash");

  // The input stage only holds a request while the result register is blocked.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> out_valid_r && !out_chan.ready)
    else $error("input stage stalled without a blocked result");

  // A new hash is produced only into a free or draining result register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !out_valid_r || out_chan.ready)
    else $error("pending hash overwritten");

endmodule
